// File: design/u8dec_pkg.sv
// Package for the UTF-8 to code point decoder.
// Holds field widths, decode constants and the result entry type.
// No dependencies.
`timescale 1ns / 1ps

package u8dec_pkg;

   // Field widths
   localparam int BYTE_W    = 8;
   localparam int CODE_W    = 21;
   localparam int PENDING_W = 2;

   // Result queue: room for one word waiting plus the two words one byte may cause
   localparam int QUEUE_DEPTH = 3;
   localparam int COUNT_W     = 2;

   // Code point emitted for malformed input
   localparam logic [CODE_W-1:0] REPLACEMENT_CODE = CODE_W'(21'h00FFFD);

   // Continuation bytes expected after each lead byte
   localparam logic [PENDING_W-1:0] PEND_NONE  = 2'd0;
   localparam logic [PENDING_W-1:0] PEND_TWO   = 2'd1;
   localparam logic [PENDING_W-1:0] PEND_THREE = 2'd2;
   localparam logic [PENDING_W-1:0] PEND_FOUR  = 2'd3;

   // Payload bits carried by each continuation byte
   localparam int CONT_BITS = 6;

   typedef struct packed {
      logic [CODE_W-1:0] code_point;
      logic              last_of_run;
   } rsp_entry_type;

endpackage

// File: design/u8dec_ifs.sv
// Channel interfaces for the UTF-8 to code point decoder.
// Valid/ready handshake with payload; depends on u8dec_pkg.
`timescale 1ns / 1ps

interface u8dec_req_if;
   import u8dec_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface u8dec_rsp_if;
   import u8dec_pkg::*;

   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] code_point;
   logic              last_of_run;

   modport source (output valid, output code_point, output last_of_run, input ready);
   modport sink   (input valid, input code_point, input last_of_run, output ready);
endinterface

// File: design/utf8_to_codepoint_decoder_core.sv
// Streaming UTF-8 decoder: one byte per req word, one code point per rsp word.
// Every byte is decoded combinationally into a three-entry result queue, and
// the queue head drives the rsp channel. One byte is accepted per cycle as long
// as the queue has room for two words after this cycle's pop: a byte that
// yields one word (or none) sustains one byte per cycle, a byte that yields two
// words (a broken sequence whose next byte also yields a word or is cut off at
// end of text) must drain both through the rsp port, so the rsp port sets the rate.
// Malformed input yields U+FFFD; last_of_run marks the final word of each byte.
`timescale 1ns / 1ps

module utf8_to_codepoint_decoder_core (
   input logic         clock,
   input logic         reset,
   u8dec_req_if.sink   req_chan,
   u8dec_rsp_if.source rsp_chan
);
   import u8dec_pkg::*;

   // Decoder state
   logic [PENDING_W-1:0] pending_ff, pending_in;
   logic [CODE_W-1:0]    partial_ff, partial_in;

   // Result queue
   rsp_entry_type        queue_ff [QUEUE_DEPTH];
   rsp_entry_type        queue_in [QUEUE_DEPTH];
   logic [COUNT_W-1:0]   count_ff, count_in;

   // Handshake
   logic                 pop;
   logic                 accept;
   logic [COUNT_W-1:0]   count_kept;

   // Decode results for the byte at the input
   rsp_entry_type        dec_res [2];
   logic [COUNT_W-1:0]   dec_cnt;

   // Pop the head, then take a byte if two slots stay free
   assign pop             = (count_ff != '0) && rsp_chan.ready;
   assign count_kept      = count_ff - COUNT_W'(pop);
   assign req_chan.ready  = (count_kept <= COUNT_W'(1));
   assign accept          = req_chan.valid && req_chan.ready;

   // Drive the head word
   assign rsp_chan.valid       = (count_ff != '0);
   assign rsp_chan.code_point  = queue_ff[0].code_point;
   assign rsp_chan.last_of_run = queue_ff[0].last_of_run;

   // Decode one byte against the open sequence
   always_comb begin
      logic [BYTE_W-1:0] b;
      logic              do_lead;
      b          = req_chan.text_byte;
      do_lead    = 1'b0;
      dec_cnt    = '0;
      dec_res[0] = '0;
      dec_res[1] = '0;
      pending_in = pending_ff;
      partial_in = partial_ff;

      if (pending_ff != PEND_NONE) begin
         if (b[7:6] == 2'b10) begin
            // Shift in six payload bits; emit when the sequence closes
            partial_in = {partial_ff[CODE_W-CONT_BITS-1:0], b[CONT_BITS-1:0]};
            pending_in = pending_ff - PENDING_W'(1);
            if (pending_in == PEND_NONE) begin
               dec_res[0].code_point = partial_in;
               dec_cnt    = COUNT_W'(1);
               partial_in = '0;
            end
         end else begin
            // Broken sequence: replace it, then read the byte as a lead byte
            dec_res[0].code_point = REPLACEMENT_CODE;
            dec_cnt    = COUNT_W'(1);
            pending_in = PEND_NONE;
            partial_in = '0;
            do_lead    = 1'b1;
         end
      end else begin
         do_lead = 1'b1;
      end

      // Lead byte decode
      if (do_lead) begin
         case (b) inside
            8'b0???????: begin
               dec_res[dec_cnt[0]].code_point = CODE_W'(b);
               dec_cnt = dec_cnt + COUNT_W'(1);
            end
            8'b110?????: begin
               partial_in = CODE_W'(b[4:0]);
               pending_in = PEND_TWO;
            end
            8'b1110????: begin
               partial_in = CODE_W'(b[3:0]);
               pending_in = PEND_THREE;
            end
            8'b11110???: begin
               partial_in = CODE_W'(b[2:0]);
               pending_in = PEND_FOUR;
            end
            default: begin
               dec_res[dec_cnt[0]].code_point = REPLACEMENT_CODE;
               dec_cnt = dec_cnt + COUNT_W'(1);
            end
         endcase
      end

      // Close a sequence cut off by end of text
      if (req_chan.end_of_text && (pending_in != PEND_NONE)) begin
         dec_res[dec_cnt[0]].code_point = REPLACEMENT_CODE;
         dec_cnt    = dec_cnt + COUNT_W'(1);
         pending_in = PEND_NONE;
         partial_in = '0;
      end

      // Mark the final word of this byte
      if (dec_cnt == COUNT_W'(1)) begin
         dec_res[0].last_of_run = 1'b1;
      end else if (dec_cnt == COUNT_W'(2)) begin
         dec_res[1].last_of_run = 1'b1;
      end
   end

   // Advance the queue and append new words behind what is kept
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && (i < QUEUE_DEPTH - 1)) begin
            queue_in[i] = queue_ff[i+1];
         end else begin
            queue_in[i] = queue_ff[i];
         end
         if (accept && (dec_cnt != '0) && (COUNT_W'(i) == count_kept)) begin
            queue_in[i] = dec_res[0];
         end
         if (accept && (dec_cnt == COUNT_W'(2)) &&
             (COUNT_W'(i) == count_kept + COUNT_W'(1))) begin
            queue_in[i] = dec_res[1];
         end
      end
      count_in = count_kept + (accept ? dec_cnt : COUNT_W'(0));
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         pending_ff <= PEND_NONE;
         partial_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            pending_ff <= pending_in;
            partial_ff <= partial_in;
         end
      end
   end

   // Hold queue payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         queue_ff[i] <= queue_in[i];
      end
   end

`ifndef ASSERT_OFF
   // Queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // No partial bits survive without an open sequence
   assert property (@(posedge clock) disable iff (reset)
      (pending_ff == PEND_NONE) |-> (partial_ff == '0))
      else $error("stale partial code with no open sequence");

   // End of text always leaves the decoder closed
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.end_of_text) |=> (pending_ff == PEND_NONE))
      else $error("sequence left open after end of text");

   // An accepted byte that yields words makes the queue non-empty
   assert property (@(posedge clock) disable iff (reset)
      (accept && (dec_cnt != '0)) |=> (count_ff != '0))
      else $error("decoded words lost");
`endif

endmodule

// File: tb/utf8_to_codepoint_decoder_core_tb.sv
// Self-checking bench for the streaming UTF-8 to code point decoder.
// Holds a code point predictor in a small class. Drives byte words and drains
// code point words with random idle cycles. Depends on u8dec_pkg and u8dec_ifs.
`timescale 1ns / 1ps

module utf8_to_codepoint_decoder_core_tb;
   import u8dec_pkg::*;

   localparam int TOTAL_BYTES  = 1150;
   localparam int MAX_IDLE     = 12;
   localparam int DRAIN_CYCLES = 8;

   // Predicts the code point words of each accepted byte and checks them in order
   class code_point_ledger;
      rsp_entry_type        awaited[$];
      logic [PENDING_W-1:0] conts_left;
      logic [CODE_W-1:0]    code_so_far;
      int unsigned          mismatches;

      function new();
         conts_left  = PEND_NONE;
         code_so_far = '0;
         mismatches  = 0;
      endfunction

      task report(input string msg);
         mismatches++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      function void push_code(input logic [CODE_W-1:0] code);
         rsp_entry_type entry;
         entry.code_point  = code;
         entry.last_of_run = 1'b0;
         awaited = {awaited, entry};
      endfunction

      // Decode a byte as the start of a new character
      function void take_lead(input logic [BYTE_W-1:0] b);
         if (b[7] == 1'b0) begin
            push_code(CODE_W'(b));
         end else if (b[7:5] == 3'b110) begin
            code_so_far = CODE_W'(b[4:0]);
            conts_left  = PEND_TWO;
         end else if (b[7:4] == 4'b1110) begin
            code_so_far = CODE_W'(b[3:0]);
            conts_left  = PEND_THREE;
         end else if (b[7:3] == 5'b11110) begin
            code_so_far = CODE_W'(b[2:0]);
            conts_left  = PEND_FOUR;
         end else begin
            // stray continuation byte or 0xF8 and above
            push_code(REPLACEMENT_CODE);
         end
      endfunction

      function void note_byte(input logic [BYTE_W-1:0] b, input logic eot);
         int first_new;
         first_new = awaited.size();
         if (conts_left != PEND_NONE) begin
            if (b[7:6] == 2'b10) begin
               // merge six payload bits, emit once the character is complete
               code_so_far = {code_so_far[CODE_W-CONT_BITS-1:0], b[CONT_BITS-1:0]};
               conts_left  = conts_left - PENDING_W'(1);
               if (conts_left == PEND_NONE) begin
                  push_code(code_so_far);
                  code_so_far = '0;
               end
            end else begin
               // broken sequence: flag it, then decode the byte again as a lead
               push_code(REPLACEMENT_CODE);
               conts_left  = PEND_NONE;
               code_so_far = '0;
               take_lead(b);
            end
         end else begin
            take_lead(b);
         end
         // sequence cut off by the end of the text
         if (eot && conts_left != PEND_NONE) begin
            push_code(REPLACEMENT_CODE);
            conts_left  = PEND_NONE;
            code_so_far = '0;
         end
         if (awaited.size() > first_new)
            awaited[awaited.size()-1].last_of_run = 1'b1;
      endfunction

      task check_word(input logic [CODE_W-1:0] code, input logic last);
         rsp_entry_type want;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected word code_point=%0h last_of_run=%0b", code, last));
         end else begin
            want = awaited.pop_front();
            if (code !== want.code_point)
               report($sformatf("code_point got %0h want %0h", code, want.code_point));
            if (last !== want.last_of_run)
               report($sformatf("last_of_run got %0b want %0b (code_point %0h)",
                                last, want.last_of_run, want.code_point));
         end
      endtask
   endclass

   logic clock;
   logic reset;

   u8dec_req_if req_bus();
   u8dec_rsp_if rsp_bus();

   utf8_to_codepoint_decoder_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   code_point_ledger ledger;
   int unsigned      bytes_sent;
   int unsigned      req_idle_max;
   int unsigned      rsp_idle_max;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the handshake hangs
   initial begin
      #5_000_000;
      $display("utf8_to_codepoint_decoder_core regression: fail");
      $finish;
   end

   // Switch the idle pattern of both sides now and then
   task pick_idle_mode();
      case ($urandom_range(0, 3))
         0: begin req_idle_max = 0;        rsp_idle_max = 0;        end
         1: begin req_idle_max = MAX_IDLE; rsp_idle_max = 0;        end
         2: begin req_idle_max = 0;        rsp_idle_max = MAX_IDLE; end
         default: begin req_idle_max = MAX_IDLE; rsp_idle_max = MAX_IDLE; end
      endcase
   endtask

   // Offer one byte word and hold it until accepted
   task send_byte(input logic [BYTE_W-1:0] b, input logic eot);
      int unsigned idle;
      idle = $urandom_range(0, req_idle_max);
      if (idle > 0) begin
         req_bus.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.text_byte   <= b;
      req_bus.end_of_text <= eot;
      do @(posedge clock); while (!req_bus.ready);
      ledger.note_byte(b, eot);
      bytes_sent++;
      if (bytes_sent % 128 == 0)
         pick_idle_mode();
   endtask

   task send_directed();
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      // two, three and four byte characters, the last one all ones
      send_byte(8'hC2, 1'b0); send_byte(8'hA9, 1'b0);
      send_byte(8'hDF, 1'b0); send_byte(8'hBF, 1'b0);
      send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hAC, 1'b0);
      send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      // invalid lead bytes at both ends of each bad range
      send_byte(8'h80, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hF8, 1'b0);
      send_byte(8'hFF, 1'b1);
      // broken sequence followed by ASCII, then by an invalid lead
      send_byte(8'hE2, 1'b0); send_byte(8'h41, 1'b0);
      send_byte(8'hC3, 1'b0); send_byte(8'hF8, 1'b0);
      // broken sequence whose new lead is cut by end of text
      send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0); send_byte(8'hE2, 1'b1);
      // plain cut by end of text, then ASCII ending a text
      send_byte(8'hC3, 1'b1);
      send_byte(8'h7F, 1'b1);
   endtask

   // Mostly well-formed characters with random payload, some cut short, some noise
   task send_random_text();
      int unsigned  pick;
      int unsigned  len;
      int unsigned  keep;
      int unsigned  k;
      logic [7:0]   r;
      logic [7:0]   lead;
      logic         eot;
      while (bytes_sent < TOTAL_BYTES) begin
         pick = $urandom_range(0, 99);
         r    = 8'($urandom_range(0, 255));
         if (pick < 85) begin
            len = (pick < 70) ? $urandom_range(1, 4) : $urandom_range(2, 4);
            case (len)
               1: lead = {1'b0, r[6:0]};
               2: lead = {3'b110, r[4:0]};
               3: lead = {4'b1110, r[3:0]};
               default: lead = {5'b11110, r[2:0]};
            endcase
            // well-formed characters send every byte, cut ones stop early
            keep = (pick < 70) ? len : $urandom_range(1, len - 1);
            for (k = 0; k < keep; k++) begin
               if (k + 1 == keep)
                  eot = (pick < 70) ? ($urandom_range(0, 15) == 0)
                                    : ($urandom_range(0, 1) == 1);
               else
                  eot = 1'b0;
               if (k == 0)
                  send_byte(lead, eot);
               else
                  send_byte({2'b10, 6'($urandom_range(0, 63))}, eot);
            end
         end else begin
            send_byte(r, $urandom_range(0, 7) == 0);
         end
      end
   endtask

   // Drain code point words with random stalls
   initial begin
      int unsigned idle;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         idle = $urandom_range(0, rsp_idle_max);
         if (idle > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (idle) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         ledger.check_word(rsp_bus.code_point, rsp_bus.last_of_run);
      end
   end

   // Reset, stimulus, drain and verdict
   initial begin
      ledger       = new();
      bytes_sent   = 0;
      req_idle_max = MAX_IDLE;
      rsp_idle_max = MAX_IDLE;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.text_byte   <= '0;
      req_bus.end_of_text <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_directed();
      pick_idle_mode();
      send_random_text();
      req_bus.valid <= 1'b0;

      while (ledger.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (ledger.mismatches == 0)
         $display("utf8_to_codepoint_decoder_core regression: pass");
      else
         $display("utf8_to_codepoint_decoder_core regression: fail");
      $finish;
   end

endmodule
